[rtl/core/rhc_pkg.sv]
// rhc_pkg: shared constants, types and the population count for the right
// homometry check. No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    // largest group order and field widths
    localparam int MAX_N  = 16;
    localparam int SET_W  = 32;
    localparam int NU_W   = 5;
    localparam int N_W    = $clog2(MAX_N + 1);
    localparam int AC_W   = $clog2(2 * MAX_N + 1);
    localparam int BC_W   = $clog2(MAX_N + 1);
    localparam int WIDE_W = SET_W + MAX_N;

    // stream and register port widths
    localparam int S_TDATA_W = 2 * SET_W;
    localparam int M_TDATA_W = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [NU_W-1:0] N_USED_RESET = NU_W'(16);

    // register word index (paddr bit above the byte offset)
    typedef enum logic {
        REG_N_USED = 1'b0
    } reg_idx_t;

    typedef logic [MAX_N-1:0] half_t;
    typedef logic [AC_W-1:0]  acnt_t;
    typedef logic [BC_W-1:0]  bcnt_t;

    // per-shift counts of one set
    typedef struct packed {
        acnt_t [MAX_N-1:0] a;
        bcnt_t [MAX_N-1:0] b;
    } corr_t;

    // number of ones in one half
    function automatic bcnt_t popcount(half_t v);
        bcnt_t c;
        c = '0;
        for (int k = 0; k < MAX_N; k++)
        begin
            c = c + BC_W'(v[k]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rhc_corr.sv]
// rhc_corr: cyclic self and cross correlation counts of one packed set,
// one lane per shift. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_corr
(
    input  wire logic [rhc_pkg::SET_W-1:0] word,
    input  wire logic [rhc_pkg::N_W-1:0]   n,
    output rhc_pkg::corr_t                 corr
);

    logic [rhc_pkg::MAX_N-1:0]    mask;
    logic [rhc_pkg::WIDE_W-1:0]   wide;
    rhc_pkg::half_t               plus_half;
    rhc_pkg::half_t               minus_half;
    logic [2*rhc_pkg::MAX_N-1:0]  dbl_plus;
    logic [2*rhc_pkg::MAX_N-1:0]  dbl_minus;
    rhc_pkg::half_t               rot_plus  [rhc_pkg::MAX_N];
    rhc_pkg::half_t               rot_minus [rhc_pkg::MAX_N];

    // split the word into its two halves of n bits
    always_comb
    begin
        for (int j = 0; j < rhc_pkg::MAX_N; j++)
        begin
            mask[j] = (rhc_pkg::N_W'(j) < n);
        end
        wide       = {{rhc_pkg::MAX_N{1'b0}}, word};
        plus_half  = wide[rhc_pkg::MAX_N-1:0] & mask;
        minus_half = rhc_pkg::MAX_N'(wide >> n) & mask;
    end

    // doubled halves: a window of n bits at offset i is the rotation by i
    always_comb
    begin
        dbl_plus  = {{rhc_pkg::MAX_N{1'b0}}, plus_half}
                  | ({{rhc_pkg::MAX_N{1'b0}}, plus_half} << n);
        dbl_minus = {{rhc_pkg::MAX_N{1'b0}}, minus_half}
                  | ({{rhc_pkg::MAX_N{1'b0}}, minus_half} << n);
    end

    // one lane per shift
    always_comb
    begin
        for (int i = 0; i < rhc_pkg::MAX_N; i++)
        begin
            rot_plus[i]  = dbl_plus[i +: rhc_pkg::MAX_N] & mask;
            rot_minus[i] = dbl_minus[i +: rhc_pkg::MAX_N] & mask;
            corr.a[i] = rhc_pkg::AC_W'(rhc_pkg::popcount(plus_half & rot_plus[i]))
                      + rhc_pkg::AC_W'(rhc_pkg::popcount(minus_half & rot_minus[i]));
            corr.b[i] = rhc_pkg::popcount(plus_half & rot_minus[i]);
        end
    end

endmodule

`default_nettype wire

[rtl/core/rhc_cmp.sv]
// rhc_cmp: compares the per-shift counts of two sets over the shifts in use.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_cmp
(
    input  wire rhc_pkg::corr_t          corr_x,
    input  wire rhc_pkg::corr_t          corr_y,
    input  wire logic [rhc_pkg::N_W-1:0] n,
    output logic                         same
);

    // any differing lane below n clears the flag
    always_comb
    begin
        same = 1'b1;
        for (int i = 0; i < rhc_pkg::MAX_N; i++)
        begin
            if ((rhc_pkg::N_W'(i) < n)
                && ((corr_x.a[i] != corr_y.a[i]) || (corr_x.b[i] != corr_y.b[i])))
            begin
                same = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/right_homometry_check.sv]
// right_homometry_check: top level, register port, three-stage pipeline
// around rhc_corr (count lanes) and rhc_cmp (lane compare). Depends on rhc_pkg.
//
//  channel   dir   handshake                 payload
//  s_*       in    s_tvalid / s_tready       s_tdata: set_x[31:0], set_y[63:32]
//  m_*       out   m_tvalid / m_tready       m_tdata: is_homometric[0], zero pad
//  apb       in    psel, penable, pready     paddr, pwdata, prdata: n_used[4:0]
//
// one request accepted per cycle unless every stage is full and the output stalls;
// a result is presented once its request has passed the input, count and result registers.
// the stage readies chain backward, so an empty stage is filled even while
// a result waits at the output.
// reset clears the stage valid bits and sets n_used to 16.
// n_used of zero acts as one, values above 16 act as 16.
`timescale 1ns / 1ps
`default_nettype none

module right_homometry_check
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rhc_pkg::S_TDATA_W-1:0]   s_tdata,   // set_x, set_y
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rhc_pkg::M_TDATA_W-1:0]        m_tdata,   // is_homometric
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rhc_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [rhc_pkg::DATA_W-1:0]      pwdata,
    output logic [rhc_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    logic [rhc_pkg::NU_W-1:0]   n_used_reg;
    logic [rhc_pkg::N_W-1:0]    n_eff;
    logic                       reg_hit;

    logic                       a_valid_reg;
    logic                       a_valid_next;
    logic [rhc_pkg::SET_W-1:0]  a_x_reg;
    logic [rhc_pkg::SET_W-1:0]  a_y_reg;
    logic [rhc_pkg::N_W-1:0]    a_n_reg;

    logic                       b_valid_reg;
    logic                       b_valid_next;
    rhc_pkg::corr_t             b_cx_reg;
    rhc_pkg::corr_t             b_cy_reg;
    logic [rhc_pkg::N_W-1:0]    b_n_reg;

    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic                       result_reg;

    logic                       a_ready;
    logic                       b_ready;
    logic                       c_ready;
    rhc_pkg::corr_t             corr_x;
    rhc_pkg::corr_t             corr_y;
    logic                       same;

    // register port
    assign pready  = 1'b1;
    assign reg_hit = (rhc_pkg::reg_idx_t'(paddr[rhc_pkg::ADDR_W-1]) == rhc_pkg::REG_N_USED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_used_reg <= rhc_pkg::N_USED_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            n_used_reg <= pwdata[rhc_pkg::NU_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = rhc_pkg::DATA_W'(n_used_reg);
        end
    end

    // clamp the group order into one to MAX_N
    always_comb
    begin
        if (n_used_reg == '0)
        begin
            n_eff = rhc_pkg::N_W'(1);
        end
        else if (32'(n_used_reg) > 32'(rhc_pkg::MAX_N))
        begin
            n_eff = rhc_pkg::N_W'(rhc_pkg::MAX_N);
        end
        else
        begin
            n_eff = rhc_pkg::N_W'(n_used_reg);
        end
    end

    // stage readies, back to front
    assign c_ready  = !m_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    always_comb
    begin
        a_valid_next = a_ready ? s_tvalid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
        m_valid_next = c_ready ? b_valid_reg : m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (a_ready && s_tvalid)
        begin
            a_x_reg <= s_tdata[rhc_pkg::SET_W-1:0];
            a_y_reg <= s_tdata[rhc_pkg::S_TDATA_W-1:rhc_pkg::SET_W];
            a_n_reg <= n_eff;
        end
    end

    // count lanes for both sets
    rhc_corr u_corr_x
    (
        .word (a_x_reg),
        .n    (a_n_reg),
        .corr (corr_x)
    );

    rhc_corr u_corr_y
    (
        .word (a_y_reg),
        .n    (a_n_reg),
        .corr (corr_y)
    );

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_cx_reg <= corr_x;
            b_cy_reg <= corr_y;
            b_n_reg  <= a_n_reg;
        end
    end

    // lane compare and result register
    rhc_cmp u_cmp
    (
        .corr_x (b_cx_reg),
        .corr_y (b_cy_reg),
        .n      (b_n_reg),
        .same   (same)
    );

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            result_reg <= same;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = rhc_pkg::M_TDATA_W'(result_reg);

    // an item held at the input stage stays while the count stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_ready) |=> (a_valid_reg && $stable(a_x_reg) && $stable(a_y_reg)))
        else $error("input stage lost a held request");

    // an accepted request always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> a_valid_reg)
        else $error("accepted request missing from input stage");

    // latched group order is always in range
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> ((a_n_reg != '0) && (32'(a_n_reg) <= 32'(rhc_pkg::MAX_N))))
        else $error("group order out of range");

    // a set compared with itself always matches
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_ready && (a_x_reg == a_y_reg)) |=> (b_valid_reg && same))
        else $error("identical sets reported as different");

    // the count stage never drops a result while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !c_ready) |=> b_valid_reg)
        else $error("count stage dropped a request");

endmodule

`default_nettype wire
